/* rtl/sms_pkg.sv */
// Shared constants, types and duty table helper for the stepper microstep sequencer.
`default_nettype none

package sms_pkg;

  // Default PWM full scale
  localparam int unsigned DUTY_FULL_SCALE = 1023;

  // Electrical slot range: 0..90 degrees in 5 degree slots
  localparam int unsigned SLOT_COUNT = 19;
  localparam logic [4:0]  SLOT_TOP   = 5'd18;
  localparam logic [4:0]  SLOT_ONE   = 5'd1;
  localparam logic [4:0]  SLOT_LAST  = 5'd17;

  // Duty saturation and cosine table scale (1e-14 units)
  localparam logic [9:0]        DUTY_MAX  = 10'd1023;
  localparam longint unsigned   TABLE_ONE = 64'd100000000000000;

  // Request kind carried in tuser
  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  // cos(5k degrees), truncated toward zero, in 1e-14 units
  localparam longint unsigned COS_TAB [SLOT_COUNT] = '{
    64'd100000000000000, 64'd99619469809174, 64'd98480775301220,
    64'd96592582628906,  64'd93969262078590, 64'd90630778703664,
    64'd86602540378443,  64'd81915204428899, 64'd76604444311897,
    64'd70710678118654,  64'd64278760968653, 64'd57357643635104,
    64'd50000000000000,  64'd42261826174069, 64'd34202014332566,
    64'd25881904510252,  64'd17364817766693, 64'd8715574274765,
    64'd0
  };

  // Duty for one slot at full scale f (low 16 bits of f used), saturated; evaluated at elaboration
  function automatic logic [9:0] duty_of(input int unsigned f, input logic [4:0] k);
    longint unsigned prod;
    prod = 64'(f & 32'h0000_FFFF) * COS_TAB[k];
    prod = prod / TABLE_ONE;
    return (prod > 64'(DUTY_MAX)) ? DUTY_MAX : prod[9:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/stepper_microstep_sequencer.sv */
// Pipeline: an accepted request is held in the input register, then goes through
// one pass of logic into the result register.
// Throughput: one request per cycle; a stalled sink blocks new requests once
// both the input register and the result register hold a request.
// Reset: asynchronous active-low; clears angle, phase, position, step count,
// direction and both valid flags.
`default_nettype none

module stepper_microstep_sequencer #(
  parameter int unsigned DUTY_FULL_SCALE = sms_pkg::DUTY_FULL_SCALE
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] target_angle
  input  wire logic [0:0]  s_axis_tuser,   // [0] func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // [0] step_valid, [2:1] phase,
                                           // [3] phase_changed, [13:4] duty_a,
                                           // [23:14] duty_b, [24] move_done, [31:25] 0
);

  // Duty table built at elaboration for the chosen full scale
  logic [9:0] duty_rom [sms_pkg::SLOT_COUNT];
  for (genvar k = 0; k < sms_pkg::SLOT_COUNT; k++) begin : g_rom
    assign duty_rom[k] = sms_pkg::duty_of(DUTY_FULL_SCALE, 5'(k));
  end

  // Input stage
  logic                 s0_valid_q;
  sms_pkg::func_e       s0_func_q;
  logic signed [15:0]   s0_angle_q;

  // Block state
  logic signed [15:0]   angle_q, angle_d;
  logic [1:0]           phase_q, phase_d;
  logic [4:0]           elec_q, elec_d;
  logic [16:0]          steps_q, steps_d;
  logic                 rev_q, rev_d;

  // Result register
  logic                 out_valid_q;
  logic [31:0]          out_data_q, out_data_d;

  logic advance;
  logic fire;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = s0_valid_q && advance;
  assign s_axis_tready = !s0_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Capture the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s0_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s0_func_q  <= sms_pkg::func_e'(s_axis_tuser[0]);
      s0_angle_q <= s_axis_tdata;
    end
  end

  // Compute next state and the result for the request in the input stage
  logic signed [16:0] delta;
  logic [16:0]        mag;
  logic               wrap;
  logic [4:0]         idx_nxt;
  logic               step_valid;
  logic               changed;
  logic               done;
  logic [9:0]         duty_a;
  logic [9:0]         duty_b;

  always_comb begin
    angle_d    = angle_q;
    phase_d    = phase_q;
    elec_d     = elec_q;
    steps_d    = steps_q;
    rev_d      = rev_q;
    step_valid = 1'b0;
    changed    = 1'b0;
    done       = 1'b0;
    duty_a     = '0;
    duty_b     = '0;
    delta      = 17'(s0_angle_q) - 17'(angle_q);
    mag        = delta[16] ? 17'(-delta) : 17'(delta);
    wrap       = rev_q ? (elec_q == 5'd0) : (elec_q == sms_pkg::SLOT_TOP);
    if (rev_q) begin
      idx_nxt = wrap ? sms_pkg::SLOT_LAST : elec_q - 5'd1;
    end else begin
      idx_nxt = wrap ? sms_pkg::SLOT_ONE : elec_q + 5'd1;
    end

    case (s0_func_q)
      sms_pkg::FUNC_LOAD: begin
        // Arm a new move from the stored angle
        rev_d   = delta[16];
        steps_d = mag + 17'd1;
        elec_d  = 5'd0;
        angle_d = s0_angle_q;
      end
      sms_pkg::FUNC_TICK: begin
        if (steps_q == '0) begin
          done = 1'b1;
        end else begin
          // Issue one microstep
          elec_d     = idx_nxt;
          changed    = wrap;
          if (wrap) begin
            phase_d = rev_q ? phase_q - 2'd1 : phase_q + 2'd1;
          end
          duty_a     = duty_rom[idx_nxt];
          duty_b     = duty_rom[sms_pkg::SLOT_TOP - idx_nxt];
          step_valid = 1'b1;
          steps_d    = steps_q - 17'd1;
          done       = (steps_q == 17'd1);
        end
      end
      default: begin
        done = 1'b0;
      end
    endcase

    out_data_d = {7'd0, done, duty_b, duty_a, changed, phase_d, step_valid};
  end

  // Update state when the request moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      phase_q <= '0;
      elec_q  <= '0;
      steps_q <= '0;
      rev_q   <= 1'b0;
    end else if (fire) begin
      angle_q <= angle_d;
      phase_q <= phase_d;
      elec_q  <= elec_d;
      steps_q <= steps_d;
      rev_q   <= rev_d;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/sms_checker.sv */
// Port-level assertions for the stepper microstep sequencer, bound to the top level.
`default_nettype none

module sms_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // No result is shown once reset has been sampled low
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Without a microstep there is no drive update and no phase change
  a_no_step_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[23:3] == 21'd0)
    else $error("drive update without a microstep");

  // A phase change only comes with a microstep
  a_change_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[0])
    else $error("phase change without a microstep");

endmodule

bind stepper_microstep_sequencer sms_checker u_sms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* tb/stepper_microstep_sequencer_tb.sv */
// Self-checking testbench for the stepper microstep sequencer stream block.
`default_nettype none

module stepper_microstep_sequencer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 10;

  // floor(1023 * cos(5k deg)) for k = 0..18
  localparam logic [9:0] COS_DUTY [sms_pkg::SLOT_COUNT] = '{
    10'd1023, 10'd1019, 10'd1007, 10'd988, 10'd961, 10'd927, 10'd885,
    10'd837,  10'd783,  10'd723,  10'd657, 10'd586, 10'd511, 10'd432,
    10'd349,  10'd264,  10'd177,  10'd89,  10'd0
  };

  typedef struct {
    sms_pkg::func_e     func;
    logic signed [15:0] angle;
  } motor_req_t;

  // Matches the m_axis_tdata layout, MSB first
  typedef struct packed {
    logic [6:0] pad;
    logic       move_done;
    logic [9:0] duty_b;
    logic [9:0] duty_a;
    logic       phase_changed;
    logic [1:0] phase;
    logic       step_valid;
  } step_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] target_angle
  logic [0:0]  s_axis_tuser = '0;   // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [0] step_valid, [2:1] phase, [3] phase_changed,
                                    // [13:4] duty_a, [23:14] duty_b, [24] move_done

  stepper_microstep_sequencer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Pending requests, the one on the bus, and expected microstep results
  motor_req_t  pend_q [$];
  motor_req_t  bus_req;
  step_res_t   step_exp_q [$];
  bit          req_taken = 1'b0;

  // Stimulus-side angle, tracked so moves can be built relative to it
  logic signed [15:0] gen_angle = '0;

  // Predicted sequencer state
  logic signed [15:0] cur_angle = '0;
  logic [1:0]         coil_phase = '0;
  logic [4:0]         elec_idx = '0;
  logic [16:0]        steps_left = '0;
  logic               rev_dir = 1'b0;

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  bit          hold_go = 1'b0;
  bit          sink_hold = 1'b0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Work out the result of one request and advance the predicted state
  function automatic step_res_t advance_sequencer(motor_req_t rq);
    step_res_t          r;
    logic signed [16:0] delta;
    logic [4:0]         idx;
    r = '0;
    if (rq.func == sms_pkg::FUNC_LOAD) begin
      delta      = {rq.angle[15], rq.angle} - {cur_angle[15], cur_angle};
      rev_dir    = delta[16];
      steps_left = (delta[16] ? 17'(-delta) : 17'(delta)) + 17'd1;
      elec_idx   = '0;
      cur_angle  = rq.angle;
    end else if (steps_left == '0) begin
      r.move_done = 1'b1;
    end else begin
      idx = (elec_idx > sms_pkg::SLOT_TOP) ? sms_pkg::SLOT_TOP : elec_idx;
      if (!rev_dir) begin
        // wrap at 90 degrees, phase forward
        if (idx == sms_pkg::SLOT_TOP) begin
          idx = '0;
          coil_phase = coil_phase + 2'd1;
          r.phase_changed = 1'b1;
        end
        idx = idx + 5'd1;
      end else begin
        // wrap at 0 degrees, phase back
        if (idx == '0) begin
          idx = sms_pkg::SLOT_TOP;
          coil_phase = coil_phase - 2'd1;
          r.phase_changed = 1'b1;
        end
        idx = idx - 5'd1;
      end
      elec_idx     = idx;
      r.duty_a     = COS_DUTY[idx];
      r.duty_b     = COS_DUTY[sms_pkg::SLOT_TOP - idx];
      r.step_valid = 1'b1;
      steps_left   = steps_left - 17'd1;
      r.move_done  = (steps_left == '0);
    end
    r.phase = coil_phase;
    return r;
  endfunction

  task automatic cmp_field(input string name, input int unsigned want,
                           input logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  // Check results in order and record accepted requests
  always @(posedge clk_i) begin
    step_res_t got;
    step_res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = step_res_t'(m_axis_tdata);
      if (step_exp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: result with none expected: tdata %h", $realtime, m_axis_tdata);
      end else begin
        want = step_exp_q.pop_front();
        cmp_field("step_valid", want.step_valid, got.step_valid);
        cmp_field("phase", want.phase, got.phase);
        cmp_field("phase_changed", want.phase_changed, got.phase_changed);
        cmp_field("duty_a", want.duty_a, got.duty_a);
        cmp_field("duty_b", want.duty_b, got.duty_b);
        cmp_field("move_done", want.move_done, got.move_done);
        cmp_field("pad", want.pad, got.pad);
      end
    end
    req_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (req_taken)
      step_exp_q.push_back(advance_sequencer(bus_req));
  end

  // Request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (pend_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        bus_req = pend_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bus_req.angle;
        s_axis_tuser  <= bus_req.func;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink with random stalls
  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && !sink_hold && ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Long sink hold-off, counted here
  initial begin
    wait (hold_go);
    @(negedge clk_i);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    sink_hold <= 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_load(input logic signed [15:0] angle);
    motor_req_t rq;
    rq.func  = sms_pkg::FUNC_LOAD;
    rq.angle = angle;
    gen_angle = angle;
    pend_q.push_back(rq);
  endtask

  // Tick carries random, ignored angle data
  task automatic push_tick();
    motor_req_t rq;
    rq.func  = sms_pkg::FUNC_TICK;
    rq.angle = 16'($urandom);
    pend_q.push_back(rq);
  endtask

  // Mostly short moves, run to completion and beyond or cut short, plus jumps and noise
  task automatic push_moves(input int n_items);
    int pushed;
    int kind;
    int d;
    int n_ticks;
    pushed = 0;
    while (pushed < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        d = int'($urandom_range(0, 120)) - 60;
        push_load(gen_angle + 16'(d));
        n_ticks = (d < 0 ? -d : d) + 1 + int'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0) n_ticks = $urandom_range(0, n_ticks);
        repeat (n_ticks) push_tick();
        pushed += n_ticks + 1;
      end else if (kind < 85) begin
        push_load(16'($urandom));
        n_ticks = $urandom_range(0, 25);
        repeat (n_ticks) push_tick();
        pushed += n_ticks + 1;
      end else if (kind < 93) begin
        push_tick();
        pushed++;
      end else begin
        push_load(16'($urandom));
        pushed++;
      end
    end
  endtask

  // Hold until every request is sent and every result is back
  task automatic wait_drained();
    while (pend_q.size() != 0 || s_axis_tvalid || step_exp_q.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed: zero-length move, tick with no steps, reverse wrap, extremes
    push_load(16'sd0);
    push_tick();
    push_tick();
    push_load(-16'sd3);
    push_tick();
    push_tick();
    push_load(16'sh7FFF);
    push_tick();
    push_tick();
    push_load(-16'sh8000);
    push_tick();
    push_tick();
    push_load(16'sd0);
    push_tick();
    push_tick();
    push_load(16'sd1);
    repeat (4) push_tick();
    wait_drained();

    // Random phases with different idle mixes
    src_idle_pct = 0;  snk_stall_pct = 0;  push_moves(200); wait_drained();
    src_idle_pct = 60; snk_stall_pct = 0;  push_moves(200); wait_drained();
    src_idle_pct = 0;  snk_stall_pct = 60; push_moves(200); wait_drained();
    src_idle_pct = 29; snk_stall_pct = 29; push_moves(200); wait_drained();

    // Back-pressure: sink held off while the source keeps offering
    src_idle_pct = 0;  snk_stall_pct = 0;
    hold_go = 1'b1;
    push_moves(200);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
